### rtl/assert_macros.svh
// Assertion helpers for the RTL. The enclosing module must have
// signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define USFI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Concurrent check that is also evaluated during reset.
`define USFI_ASSERT_NR(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

### rtl/usfi_pkg.sv
package usfi_pkg;

   localparam int POS_W = 12;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_HOTFIX  = 2'd1;
   localparam logic [1:0] STATUS_CORRUPT = 2'd2;

   localparam logic [3:0] CFG_RESET = 4'd2;

   // Everything the edit sequencer needs from the captured record.
   typedef struct packed {
      logic [7:0][7:0] hdr;
      logic [15:0]     seq_word;
      logic [3:0]      sectors;
   } usfi_rec_type;

endpackage

### rtl/usfi_capture.sv
module usfi_capture #(
   parameter int MAX_SECTORS  = 8,
   parameter int SECTOR_BYTES = 512
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   input  logic [3:0]               csr_data,
   input  logic                     accept,
   input  logic [7:0]               rec_byte,
   input  logic [$clog2((MAX_SECTORS > 1) ? MAX_SECTORS : 2)-1:0] tail_sel,
   output logic                     rec_end,
   output usfi_pkg::usfi_rec_type   rec,
   output logic [15:0]              tail_word
);
   import usfi_pkg::*;

   localparam int ISW    = $clog2(SECTOR_BYTES);
   localparam int SIDX_W = $clog2(4096 / SECTOR_BYTES + MAX_SECTORS + 1);
   localparam int TIDX_W = $clog2((MAX_SECTORS > 1) ? MAX_SECTORS : 2);

   logic [3:0]        cfg_ff;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [ISW-1:0]    insec_ff, insec_in;
   logic [SIDX_W-1:0] sidx_ff, sidx_in;
   logic [7:0]        hdr_ff [8];
   logic [15:0]       seq_ff;
   logic [15:0]       tail_ff [MAX_SECTORS];

   logic [3:0]  eff;
   logic [16:0] len;
   logic        is_end;
   logic [15:0] first;
   logic        tail_ok;

   always_comb begin
      if (cfg_ff == 4'd0) begin
         eff = 4'd1;
      end else if ({1'b0, cfg_ff} > 5'(MAX_SECTORS)) begin
         eff = 4'(MAX_SECTORS);
      end else begin
         eff = cfg_ff;
      end
   end

   assign len     = 17'(eff) * 17'(SECTOR_BYTES);
   assign is_end  = ({5'd0, pos_ff} + 17'd1) >= len;
   assign first   = {hdr_ff[5], hdr_ff[4]};
   assign tail_ok = sidx_ff < SIDX_W'(MAX_SECTORS);
   assign rec_end = accept && is_end;

   // Position, offset within the sector and sector index move together.
   always_comb begin
      pos_in   = pos_ff;
      insec_in = insec_ff;
      sidx_in  = sidx_ff;
      if (accept) begin
         if (is_end || (pos_ff == {POS_W{1'b1}})) begin
            pos_in   = '0;
            insec_in = '0;
            sidx_in  = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            if (insec_ff == ISW'(SECTOR_BYTES - 1)) begin
               insec_in = '0;
               sidx_in  = sidx_ff + SIDX_W'(1);
            end else begin
               insec_in = insec_ff + ISW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= CFG_RESET;
         pos_ff   <= '0;
         insec_ff <= '0;
         sidx_ff  <= '0;
      end else begin
         if (csr_valid) begin
            cfg_ff <= csr_data;
         end
         pos_ff   <= pos_in;
         insec_ff <= insec_in;
         sidx_ff  <= sidx_in;
      end
   end

   // Captured bytes carry no reset; each is written before it is read.
   always_ff @(posedge clock) begin
      if (accept) begin
         if (pos_ff < POS_W'(8)) begin
            hdr_ff[pos_ff[2:0]] <= rec_byte;
         end else begin
            if ({4'd0, pos_ff} == first) begin
               seq_ff[7:0] <= rec_byte;
            end
            if ({5'd0, pos_ff} == ({1'b0, first} + 17'd1)) begin
               seq_ff[15:8] <= rec_byte;
            end
         end
         if (tail_ok) begin
            if (insec_ff == ISW'(SECTOR_BYTES - 2)) begin
               tail_ff[sidx_ff[TIDX_W-1:0]][7:0] <= rec_byte;
            end else if (insec_ff == ISW'(SECTOR_BYTES - 1)) begin
               tail_ff[sidx_ff[TIDX_W-1:0]][15:8] <= rec_byte;
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         rec.hdr[i] = hdr_ff[i];
      end
      rec.seq_word = seq_ff;
      rec.sectors  = eff;
   end

   assign tail_word = tail_ff[tail_sel];

endmodule

### rtl/usfi_seq.sv
`include "assert_macros.svh"

module usfi_seq #(
   parameter int MAX_SECTORS  = 8,
   parameter int SECTOR_BYTES = 512
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rec_end,
   input  usfi_pkg::usfi_rec_type   rec,
   input  logic [15:0]              tail_word,
   output logic [$clog2((MAX_SECTORS > 1) ? MAX_SECTORS : 2)-1:0] tail_sel,
   output logic                     busy,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic                     rsp_edit_valid,
   output logic [11:0]              rsp_edit_offset,
   output logic [7:0]               rsp_edit_byte,
   output logic [1:0]               rsp_status,
   output logic                     rsp_last_edit
);
   import usfi_pkg::*;

   localparam int         TIDX_W     = $clog2((MAX_SECTORS > 1) ? MAX_SECTORS : 2);
   localparam logic [11:0] SB12      = 12'(SECTOR_BYTES % 4096);
   localparam logic [11:0] TAIL0_OFF = 12'((SECTOR_BYTES - 2) % 4096);
   localparam logic [11:0] COUNT_LO  = 12'd6;
   localparam logic [11:0] COUNT_HI  = 12'd7;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_BAD, ST_HOT0, ST_HOT1, ST_FIX0, ST_FIX1,
      ST_ARR0, ST_ARR1, ST_TAIL0, ST_TAIL1
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  sect_ff, sect_in;
   logic [3:0]  s_ff, s_in;
   logic [11:0] first_ff, first_in;
   logic [11:0] arr_ff, arr_in;
   logic [11:0] tail_ff, tail_in;
   logic [15:0] fix_ff, fix_in;
   logic        hot_ff, hot_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_edit_valid_ff, rsp_edit_valid_in;
   logic [11:0] rsp_edit_offset_ff, rsp_edit_offset_in;
   logic [7:0]  rsp_edit_byte_ff, rsp_edit_byte_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_last_edit_ff, rsp_last_edit_in;

   logic [4:0]      count;
   logic [15:0]     first16;
   logic            hot;
   logic            bad;
   logic [7:0][7:0] hf;
   logic [7:0]      lo, hi;
   logic [15:0]     add_a, add_b, sum;
   logic [15:0]     fix_val;
   logic            slot_free;
   logic            load;
   logic [1:0]      ok_status;

   assign count     = {1'b0, sect_ff} + 5'd1;
   assign first16   = {rec.hdr[5], rec.hdr[4]};
   assign hot       = {rec.hdr[7], rec.hdr[6]} != {11'd0, count};
   assign bad       = ({1'b0, first16} + {11'd0, count, 1'b0}) > 17'(SECTOR_BYTES - 2);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign ok_status = hot_ff ? STATUS_HOTFIX : STATUS_OK;

   // The sequence word is read after the count correction has been applied.
   always_comb begin
      hf    = rec.hdr;
      hf[6] = hot ? {3'd0, count} : rec.hdr[6];
      hf[7] = hot ? 8'd0 : rec.hdr[7];
      lo    = (first16 < 16'd8) ? hf[first16[2:0]] : rec.seq_word[7:0];
      hi    = (first16 < 16'd7) ? hf[first16[2:0] + 3'd1] : rec.seq_word[15:8];
   end

   // Shared adder: the sequence increment, then the sequence, array and tail edit offsets.
   always_comb begin
      add_a = '0;
      add_b = '0;
      case (state_ff)
         ST_CHECK: begin
            add_a = {hi, lo};
            add_b = 16'd1;
         end
         ST_FIX0:  add_a = {4'd0, first_ff};
         ST_FIX1: begin
            add_a = {4'd0, first_ff};
            add_b = 16'd1;
         end
         ST_ARR0:  add_a = {4'd0, arr_ff};
         ST_ARR1: begin
            add_a = {4'd0, arr_ff};
            add_b = 16'd1;
         end
         ST_TAIL0: add_a = {4'd0, tail_ff};
         ST_TAIL1: begin
            add_a = {4'd0, tail_ff};
            add_b = 16'd1;
         end
         default: begin
            add_a = '0;
            add_b = '0;
         end
      endcase
   end

   assign sum     = add_a + add_b;
   assign fix_val = ((sum == 16'd0) || (sum == 16'hFFFF)) ? 16'd1 : sum;

   always_comb begin
      state_in           = state_ff;
      sect_in            = sect_ff;
      s_in               = s_ff;
      first_in           = first_ff;
      arr_in             = arr_ff;
      tail_in            = tail_ff;
      fix_in             = fix_ff;
      hot_in             = hot_ff;
      load               = 1'b0;
      rsp_edit_valid_in  = 1'b1;
      rsp_edit_offset_in = sum[11:0];
      rsp_edit_byte_in   = 8'd0;
      rsp_status_in      = ok_status;
      rsp_last_edit_in   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (rec_end) begin
               sect_in  = rec.sectors;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            fix_in   = fix_val;
            hot_in   = hot;
            first_in = first16[11:0];
            arr_in   = first16[11:0] + 12'd2;
            tail_in  = TAIL0_OFF;
            s_in     = 4'd0;
            if (bad) begin
               state_in = ST_BAD;
            end else if (hot) begin
               state_in = ST_HOT0;
            end else begin
               state_in = ST_FIX0;
            end
         end
         ST_BAD: begin
            rsp_edit_valid_in  = 1'b0;
            rsp_edit_offset_in = 12'd0;
            rsp_status_in      = STATUS_CORRUPT;
            rsp_last_edit_in   = 1'b1;
            if (slot_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_HOT0: begin
            rsp_edit_offset_in = COUNT_LO;
            rsp_edit_byte_in   = {3'd0, count};
            if (slot_free) begin
               load     = 1'b1;
               state_in = ST_HOT1;
            end
         end
         ST_HOT1: begin
            rsp_edit_offset_in = COUNT_HI;
            if (slot_free) begin
               load     = 1'b1;
               state_in = ST_FIX0;
            end
         end
         ST_FIX0: begin
            rsp_edit_byte_in = fix_ff[7:0];
            if (slot_free) begin
               load     = 1'b1;
               state_in = ST_FIX1;
            end
         end
         ST_FIX1: begin
            rsp_edit_byte_in = fix_ff[15:8];
            if (slot_free) begin
               load     = 1'b1;
               state_in = ST_ARR0;
            end
         end
         ST_ARR0: begin
            rsp_edit_byte_in = tail_word[7:0];
            if (slot_free) begin
               load     = 1'b1;
               state_in = ST_ARR1;
            end
         end
         ST_ARR1: begin
            rsp_edit_byte_in = tail_word[15:8];
            if (slot_free) begin
               load     = 1'b1;
               state_in = ST_TAIL0;
            end
         end
         ST_TAIL0: begin
            rsp_edit_byte_in = fix_ff[7:0];
            if (slot_free) begin
               load     = 1'b1;
               state_in = ST_TAIL1;
            end
         end
         ST_TAIL1: begin
            rsp_edit_byte_in = fix_ff[15:8];
            rsp_last_edit_in = (s_ff == (sect_ff - 4'd1));
            if (slot_free) begin
               load    = 1'b1;
               arr_in  = arr_ff + 12'd2;
               tail_in = tail_ff + SB12;
               if (rsp_last_edit_in) begin
                  state_in = ST_IDLE;
               end else begin
                  s_in     = s_ff + 4'd1;
                  state_in = ST_ARR0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sect_ff  <= sect_in;
      s_ff     <= s_in;
      first_ff <= first_in;
      arr_ff   <= arr_in;
      tail_ff  <= tail_in;
      fix_ff   <= fix_in;
      hot_ff   <= hot_in;
      if (load) begin
         rsp_edit_valid_ff  <= rsp_edit_valid_in;
         rsp_edit_offset_ff <= rsp_edit_offset_in;
         rsp_edit_byte_ff   <= rsp_edit_byte_in;
         rsp_status_ff      <= rsp_status_in;
         rsp_last_edit_ff   <= rsp_last_edit_in;
      end
   end

   assign tail_sel        = s_ff[TIDX_W-1:0];
   assign busy            = state_ff != ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_edit_valid  = rsp_edit_valid_ff;
   assign rsp_edit_offset = rsp_edit_offset_ff;
   assign rsp_edit_byte   = rsp_edit_byte_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_edit   = rsp_last_edit_ff;

   `USFI_ASSERT(a_end_while_idle, rec_end |-> state_ff == ST_IDLE, "record end while busy")
   `USFI_ASSERT(a_corrupt_alone, (rsp_valid_ff && rsp_status_ff == STATUS_CORRUPT) |-> (rsp_last_edit_ff && !rsp_edit_valid_ff), "corrupt beat carries an edit")
   `USFI_ASSERT(a_sector_range, (state_ff == ST_TAIL1) |-> (s_ff < sect_ff), "sector index out of range")
   `USFI_ASSERT_NR(a_reset_clean, reset |=> (!rsp_valid_ff && state_ff == ST_IDLE), "not clean after reset")

endmodule

### rtl/update_sequence_fixup_insert.sv
// Channel   Direction  Beat contents
// req       in         rec_byte: one record byte, offset zero upward
// rsp       out        edit_valid, edit_offset, edit_byte, status, last_edit
// csr       in         sectors_per_record, to be written by the user only
//                       while the block is idle; the block does not enforce it.
// Record bytes are taken at one per cycle; only the final byte of a record
// starts the edit sequencer, and req_ready stays low while it runs.
// The sequencer first computes the sequence-number increment, then issues
// the edit beats: 2 + 4 * sectors beats, plus 2 with the count hotfix.
// A corrupt array position yields a single beat, from the bad state.
// A stalled rsp_ready holds the sequencer on the current beat.
// Synchronous reset clears the position counter, the sequencer and the
// output valid, and sets sectors_per_record to 2.
module update_sequence_fixup_insert #(
   parameter int MAX_SECTORS  = 8,
   parameter int SECTOR_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rec_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_edit_valid,
   output logic [11:0] rsp_edit_offset,
   output logic [7:0]  rsp_edit_byte,
   output logic [1:0]  rsp_status,
   output logic        rsp_last_edit,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_sectors_per_record
);
   import usfi_pkg::*;

   localparam int TIDX_W = $clog2((MAX_SECTORS > 1) ? MAX_SECTORS : 2);

   logic              accept;
   logic              rec_end;
   logic              busy;
   usfi_rec_type      rec;
   logic [15:0]       tail_word;
   logic [TIDX_W-1:0] tail_sel;

   // The register write never stalls.
   assign csr_ready = 1'b1;
   // Input beats are taken whenever the edit sequencer is not running.
   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;

   // Byte position tracking and capture of header, sequence word and tails.
   usfi_capture #(
      .MAX_SECTORS  (MAX_SECTORS),
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_capture (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_sectors_per_record),
      .accept    (accept),
      .rec_byte  (req_rec_byte),
      .tail_sel  (tail_sel),
      .rec_end   (rec_end),
      .rec       (rec),
      .tail_word (tail_word)
   );

   // Edit sequencer with the shared adder and the output register.
   usfi_seq #(
      .MAX_SECTORS  (MAX_SECTORS),
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .rec_end         (rec_end),
      .rec             (rec),
      .tail_word       (tail_word),
      .tail_sel        (tail_sel),
      .busy            (busy),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_edit_valid  (rsp_edit_valid),
      .rsp_edit_offset (rsp_edit_offset),
      .rsp_edit_byte   (rsp_edit_byte),
      .rsp_status      (rsp_status),
      .rsp_last_edit   (rsp_last_edit)
   );

endmodule

### bench/update_sequence_fixup_insert_tb.sv
module update_sequence_fixup_insert_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import usfi_pkg::*;

   localparam int MAX_SECTORS  = 8;
   localparam int SECTOR_BYTES = 512;
   // Cycles the receiver holds off once in a while, long enough for the
   // block to sit on a full edit beat with the next record waiting behind it.
   localparam int HOLD_CYCLES  = 400;

   // One edit beat as it appears on the rsp channel.
   typedef struct {
      logic        edit_valid;
      logic [11:0] edit_offset;
      logic [7:0]  edit_byte;
      logic [1:0]  status;
      logic        last_edit;
   } edit_beat_type;

   // Effective sector count: zero reads as one sector, anything above the
   // array depth is clamped to it.
   function automatic int eff_sectors(logic [3:0] s);
      int e;
      e = s;
      if (e < 1) e = 1;
      if (e > MAX_SECTORS) e = MAX_SECTORS;
      return e;
   endfunction

   // The scoreboard mirrors the block: it follows the byte stream, keeps the
   // header, the sequence word and the sector tails, and when a record closes
   // it queues the edit beats the block must produce.
   class fixup_scoreboard;
      logic [3:0]    sectors_csr;
      logic [11:0]   position;
      logic [7:0]    hdr[8];
      logic [15:0]   seq_src;
      logic [15:0]   tails[MAX_SECTORS];
      edit_beat_type expected_edits[$];
      int            errors;

      function new();
         sectors_csr = CFG_RESET;
         position = '0;
         errors = 0;
      endfunction

      function void set_sectors(logic [3:0] v);
         sectors_csr = v;
      endfunction

      function void note_byte(logic [7:0] b);
         int p, len, in_sec, sidx, first;
         p = position;
         len = eff_sectors(sectors_csr) * SECTOR_BYTES;
         in_sec = p % SECTOR_BYTES;
         sidx = p / SECTOR_BYTES;
         if (p < 8) begin
            hdr[p] = b;
         end else begin
            first = {hdr[5], hdr[4]};
            if (p == first) seq_src[7:0] = b;
            if (p == first + 1) seq_src[15:8] = b;
         end
         if (sidx < MAX_SECTORS) begin
            if (in_sec == SECTOR_BYTES - 2) tails[sidx][7:0] = b;
            else if (in_sec == SECTOR_BYTES - 1) tails[sidx][15:8] = b;
         end
         if (p + 1 >= len) begin
            position = '0;
            close_record();
         end else begin
            position = 12'(p + 1);
         end
      endfunction

      function void close_record();
         int            sectors, cnt, first, n, s, arr, tail;
         int            offs[40];
         logic [7:0]    vals[40];
         logic [7:0]    lo, hi;
         logic [15:0]   fix;
         logic [1:0]    st;
         edit_beat_type beat;
         sectors = eff_sectors(sectors_csr);
         cnt = sectors + 1;
         first = {hdr[5], hdr[4]};
         if (first + 2 * cnt > SECTOR_BYTES - 2) begin
            beat.edit_valid = 1'b0;
            beat.edit_offset = '0;
            beat.edit_byte = '0;
            beat.status = STATUS_CORRUPT;
            beat.last_edit = 1'b1;
            expected_edits.push_back(beat);
            return;
         end
         st = STATUS_OK;
         n = 0;
         // A wrong count is repaired first, and the repaired bytes are what a
         // sequence word overlapping them is read from.
         if ({hdr[7], hdr[6]} != 16'(cnt)) begin
            st = STATUS_HOTFIX;
            hdr[6] = cnt[7:0];
            hdr[7] = cnt[15:8];
            offs[n] = 6; vals[n] = hdr[6]; n++;
            offs[n] = 7; vals[n] = hdr[7]; n++;
         end
         lo = (first < 8) ? hdr[first] : seq_src[7:0];
         hi = (first + 1 < 8) ? hdr[first + 1] : seq_src[15:8];
         fix = {hi, lo} + 16'd1;
         if (fix == 16'hffff || fix == 16'h0000) fix = 16'd1;
         offs[n] = first;     vals[n] = fix[7:0];  n++;
         offs[n] = first + 1; vals[n] = fix[15:8]; n++;
         for (s = 0; s < sectors; s++) begin
            arr = first + 2 * (s + 1);
            tail = (s + 1) * SECTOR_BYTES - 2;
            offs[n] = arr;      vals[n] = tails[s][7:0];  n++;
            offs[n] = arr + 1;  vals[n] = tails[s][15:8]; n++;
            offs[n] = tail;     vals[n] = fix[7:0];       n++;
            offs[n] = tail + 1; vals[n] = fix[15:8];      n++;
         end
         for (s = 0; s < n; s++) begin
            beat.edit_valid = 1'b1;
            beat.edit_offset = offs[s][11:0];
            beat.edit_byte = vals[s];
            beat.status = st;
            beat.last_edit = (s == n - 1);
            expected_edits.push_back(beat);
         end
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_edit(edit_beat_type got);
         edit_beat_type want;
         if (expected_edits.size() == 0) begin
            $error("edit beat with nothing expected: offset 0x%0h, byte 0x%0h",
                   got.edit_offset, got.edit_byte);
            errors++;
            return;
         end
         want = expected_edits.pop_front();
         compare_field("edit_valid", want.edit_valid, got.edit_valid);
         compare_field("edit_offset", want.edit_offset, got.edit_offset);
         compare_field("edit_byte", want.edit_byte, got.edit_byte);
         compare_field("status", want.status, got.status);
         compare_field("last_edit", want.last_edit, got.last_edit);
      endfunction
   endclass

   // Every input of the block starts at a known value, with reset held high.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rec_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_edit_valid;
   logic [11:0] rsp_edit_offset;
   logic [7:0]  rsp_edit_byte;
   logic [1:0]  rsp_status;
   logic        rsp_last_edit;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_sectors_per_record = '0;

   fixup_scoreboard sb = new();

   // Stimulus-side copy of the register, so record lengths are known at once
   // after a write without racing the monitor.
   logic [3:0]  cur_sectors = CFG_RESET;
   // Per-record switches for random gaps on each side, and a one-shot
   // request for the long receiver hold-off.
   bit          tx_idle = 1'b0;
   bit          rx_idle = 1'b0;
   bit          stall_armed = 1'b0;
   logic [7:0]  record_buf [0:4095];

   update_sequence_fixup_insert #(
      .MAX_SECTORS(MAX_SECTORS),
      .SECTOR_BYTES(SECTOR_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rec_byte(req_rec_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_edit_valid(rsp_edit_valid),
      .rsp_edit_offset(rsp_edit_offset),
      .rsp_edit_byte(rsp_edit_byte),
      .rsp_status(rsp_status),
      .rsp_last_edit(rsp_last_edit),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_sectors_per_record(csr_sectors_per_record)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The monitor samples every channel at the rising edge. All stimulus is
   // driven with nonblocking assignments, so the values seen here are the
   // ones the block saw at the same edge.
   always @(posedge clock) begin
      edit_beat_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_sectors(csr_sectors_per_record);
         if (req_valid && req_ready) sb.note_byte(req_rec_byte);
         if (rsp_valid && rsp_ready) begin
            got.edit_valid = rsp_edit_valid;
            got.edit_offset = rsp_edit_offset;
            got.edit_byte = rsp_edit_byte;
            got.status = rsp_status;
            got.last_edit = rsp_last_edit;
            sb.check_edit(got);
         end
      end
   end

   // Receiver. Before each beat it may drop ready for a random number of
   // cycles. When a long hold-off is armed it keeps ready low for a fixed
   // stretch, counted here, while the sender keeps offering the next record.
   initial begin
      int gap;
      wait (reset == 1'b0);
      forever begin
         if (stall_armed) begin
            stall_armed = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = rx_idle ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Offers one record byte, after an optional gap, and returns at the edge
   // where the beat is taken. Valid stays high across back-to-back beats.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = tx_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rec_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   // Withdraws the sender, lets the monitor finish with the last accepted
   // byte, waits until every expected beat has come back, then a few more
   // cycles so the sequencer has surely returned to idle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_edits.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // The register is only written with the block idle.
   task automatic write_sectors(input logic [3:0] v);
      wait_drained();
      csr_valid <= 1'b1;
      csr_sectors_per_record <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_sectors = v;
   endtask

   // Builds one record of random bytes at the current length. The sequence
   // word goes in first, then the header fields, so a sequence word that
   // overlaps the header is overwritten by the array offset or the count.
   task automatic send_record(input int first, input int count_word, input int seq_word);
      int len, i;
      len = eff_sectors(cur_sectors) * SECTOR_BYTES;
      for (i = 0; i < len; i++) record_buf[i] = 8'($urandom_range(0, 255));
      if (first + 1 < len) begin
         record_buf[first] = seq_word[7:0];
         record_buf[first + 1] = seq_word[15:8];
      end
      record_buf[4] = first[7:0];
      record_buf[5] = first[15:8];
      record_buf[6] = count_word[7:0];
      record_buf[7] = count_word[15:8];
      for (i = 0; i < len; i++) send_byte(record_buf[i]);
   endtask

   initial begin
      int r, roll, cnt, maxfirst, first, count_word, seq_word;
      logic [3:0] v;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed records. The first runs at the reset length of two sectors.
      send_record(48, 3, 16'h1234);

      // One sector from here. The long receiver hold-off lands on this
      // record, which also has a sequence number that wraps to zero.
      write_sectors(4'd1);
      stall_armed = 1'b1;
      send_record(8, 2, 16'hffff);

      tx_idle = 1'b1;
      rx_idle = 1'b1;
      // The increment lands on 0xffff, which is also replaced by one.
      send_record(200, 2, 16'hfffe);
      // Count of zero forces the hotfix; sequence word of zero is plain.
      send_record(300, 0, 16'h0000);
      // Count wrong only in its high byte.
      send_record(16, 16'hff02, $urandom_range(0, 65535));
      // Sequence word sits on the count bytes, so it is read after repair.
      send_record(6, 16'h0005, 0);
      // Sequence word straddles the header end: low byte from header byte 7.
      send_record(7, 2, 16'h00ab);
      // Sequence word at the very start of the header.
      send_record(0, 2, $urandom_range(0, 65535));
      // Array ends exactly at the last allowed byte.
      send_record(506, 2, $urandom_range(0, 65535));
      // One past that is a corrupt position.
      send_record(507, 2, $urandom_range(0, 65535));
      // Largest possible offset, with a wrong count as well: corrupt wins.
      send_record(16'hffff, 16'h1234, $urandom_range(0, 65535));

      // Register zero reads as one sector.
      write_sectors(4'd0);
      send_record(100, 2, $urandom_range(0, 65535));

      // Register fifteen is clamped to eight sectors; array at its limit.
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      write_sectors(4'd15);
      send_record(492, 9, $urandom_range(0, 65535));

      tx_idle = 1'b1;
      rx_idle = 1'b1;
      write_sectors(4'd3);
      send_record(40, 7, $urandom_range(0, 65535));

      // Random records. Most have an array that fits and random content, since
      // only those reach the per-sector edits, and some of these carry a bad count;
      // the rest have an array that does not fit. Lengths stay mostly at one or two sectors.
      for (r = 0; r < 40; r++) begin
         if (r % 4 == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) v = 4'($urandom_range(0, 1));
            else if (roll < 75) v = 4'd2;
            else if (roll < 92) v = 4'($urandom_range(3, 7));
            else v = 4'($urandom_range(8, 15));
            write_sectors(v);
         end
         tx_idle = $urandom_range(0, 1);
         rx_idle = $urandom_range(0, 1);
         if (r == 21) stall_armed = 1'b1;

         cnt = eff_sectors(cur_sectors) + 1;
         maxfirst = SECTOR_BYTES - 2 - 2 * cnt;
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            first = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 7)
                                                : $urandom_range(8, maxfirst);
            count_word = (roll < 58) ? cnt : $urandom_range(0, 65535);
         end else if (roll < 85) begin
            first = $urandom_range(maxfirst + 1, SECTOR_BYTES + 8);
            count_word = $urandom_range(0, 1) ? cnt : $urandom_range(0, 65535);
         end else begin
            first = $urandom_range(maxfirst + 1, 65535);
            count_word = $urandom_range(0, 65535);
         end
         case ($urandom_range(0, 11))
            0: seq_word = 16'hffff;
            1: seq_word = 16'hfffe;
            2: seq_word = 16'h0000;
            default: seq_word = $urandom_range(0, 65535);
         endcase
         send_record(first, count_word, seq_word);
      end

      // Drain, then give the block time to show any stray beat.
      wait_drained();
      repeat (40) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #25_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
